[sv/u8cbc_pkg.sv]
`default_nettype none

package u8cbc_pkg;

  localparam int unsigned MAX_STRING_BYTES_DEF = 255;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned PEND_W = 3;
  localparam logic [COUNT_W-1:0] COUNT_TOP = 8'hFF;
  localparam logic [7:0] LEAD_MASK = 8'h80;
  localparam int unsigned MAX_SEQ_LEN = 7;

  // running per-string state
  typedef struct packed {
    logic [PEND_W-1:0]  pend;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] chars;
    logic [COUNT_W-1:0] leads;
    logic               err;
  } state_t;

  // one result item
  typedef struct packed {
    logic               char_start;
    logic [COUNT_W-1:0] char_index;
    logic [COUNT_W-1:0] byte_offset;
    logic               encoding_error;
    logic               string_done;
    logic [COUNT_W-1:0] char_length;
    logic [COUNT_W-1:0] multibyte_count;
  } res_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v,
                                                 input logic [COUNT_W-1:0] top);
    sat_inc = (v >= top) ? top : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

[sv/u8cbc_if.sv]
`default_nettype none

interface u8cbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8cbc_out_if;
  logic       valid;
  logic       ready;
  logic       char_start;
  logic [7:0] char_index;
  logic [7:0] byte_offset;
  logic       encoding_error;
  logic       string_done;
  logic [7:0] char_length;
  logic [7:0] multibyte_count;

  modport source (output valid, output char_start, output char_index, output byte_offset,
                  output encoding_error, output string_done, output char_length,
                  output multibyte_count, input ready);
  modport sink (input valid, input char_start, input char_index, input byte_offset,
                input encoding_error, input string_done, input char_length,
                input multibyte_count, output ready);
endinterface

`default_nettype wire

[sv/utf8_char_boundary_checker_core.sv]
`default_nettype none

// utf8 character boundary checker. bytes of a string enter one per item on in_ch,
// last_byte marking the final byte; each byte yields exactly one result item on
// out_ch saying whether it opens a character, the index of its character and its
// byte offset. a byte with bit 7 set opens a sequence whose length is its count of
// leading ones (capped at 7); the bytes it claims must have bit 7 set, else a
// sticky encoding_error rises, as it does when the last byte leaves a sequence
// open. zero bytes are not counted. char_length and multibyte_count read 0 while
// the error is up, and all counters saturate at 255 (byte_offset at
// MAX_STRING_BYTES). state clears after the last byte. timing: an item waits in
// the input register, the per-byte logic and state update act on it there, and
// the result lands in the output register; the block takes one byte every cycle
// while out_ch keeps up, the loop that sets this rate being the state update
// between successive bytes.
module utf8_char_boundary_checker_core #(
  parameter int unsigned MAX_STRING_BYTES = u8cbc_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  u8cbc_in_if.sink    in_ch,
  u8cbc_out_if.source out_ch
);
  import u8cbc_pkg::*;

  // input register
  logic       in_vld;
  logic [7:0] in_data;
  logic       in_last;

  // result register
  logic out_vld;
  res_t out_res;

  // per-string running state
  state_t st;
  state_t st_next;
  res_t   res_next;

  logic out_free;
  logic step_fire;
  logic in_fire;

  assign out_free  = !out_vld || out_ch.ready;
  assign step_fire = in_vld && out_free;
  // input register frees as its item moves on, so a byte can follow every cycle
  assign in_ch.ready = !in_vld || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  u8cbc_step #(
    .MAX_STRING_BYTES(MAX_STRING_BYTES)
  ) u_step (
    .cur      (st),
    .data_byte(in_data),
    .last_byte(in_last),
    .nxt      (st_next),
    .res      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      st      <= '0;
    end else begin
      if (in_fire) begin
        in_vld <= 1'b1;
      end else if (step_fire) begin
        in_vld <= 1'b0;
      end
      if (step_fire) begin
        out_vld <= 1'b1;
        st      <= st_next;
      end else if (out_ch.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data <= in_ch.data_byte;
      in_last <= in_ch.last_byte;
    end
    if (step_fire) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid           = out_vld;
  assign out_ch.char_start      = out_res.char_start;
  assign out_ch.char_index      = out_res.char_index;
  assign out_ch.byte_offset     = out_res.byte_offset;
  assign out_ch.encoding_error  = out_res.encoding_error;
  assign out_ch.string_done     = out_res.string_done;
  assign out_ch.char_length     = out_res.char_length;
  assign out_ch.multibyte_count = out_res.multibyte_count;

  // the final byte of a string leaves the state fully cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (step_fire && in_last) |=> (st == '0))
    else $error("state not cleared after last byte");

  // every lead byte is also a counted character
  a_leads_le_chars: assert property (@(posedge clk) disable iff (rst)
    st.leads <= st.chars)
    else $error("lead count exceeds character count");

  // a byte claimed by an open sequence never starts a character
  a_cont_no_start: assert property (@(posedge clk) disable iff (rst)
    (step_fire && st.pend != '0) |=> !out_res.char_start)
    else $error("continuation byte flagged as character start");

  // an item waiting in the input register moves on as soon as the output frees
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !out_vld) |=> out_vld)
    else $error("result register idled with a byte waiting");

endmodule

`default_nettype wire

[sv/u8cbc_step.sv]
`default_nettype none

module u8cbc_step #(
  parameter int unsigned MAX_STRING_BYTES = u8cbc_pkg::MAX_STRING_BYTES_DEF
) (
  input  u8cbc_pkg::state_t cur,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output u8cbc_pkg::state_t nxt,
  output u8cbc_pkg::res_t   res
);
  import u8cbc_pkg::*;

  localparam logic [COUNT_W-1:0] MaxPos = COUNT_W'(MAX_STRING_BYTES);

  logic [PEND_W-1:0] ones_extra;
  logic              run;
  state_t            mid;
  logic              err_out;

  // leading ones after bit 7, bits 6 down to 1, gives the owed continuations
  always_comb begin
    ones_extra = '0;
    run = 1'b1;
    for (int i = 6; i >= 1; i--) begin
      if (run && data_byte[i]) begin
        ones_extra = ones_extra + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    mid = cur;
    res = '0;
    if (cur.pend != '0) begin
      if ((data_byte & LEAD_MASK) == '0) begin
        mid.err = 1'b1;
      end
      mid.pend = cur.pend - 1'b1;
      if (cur.chars == COUNT_TOP) begin
        res.char_index = COUNT_TOP;
      end else if (cur.chars == '0) begin
        res.char_index = '0;
      end else begin
        res.char_index = cur.chars - 1'b1;
      end
    end else if (data_byte[7]) begin
      mid.pend = ones_extra;
      res.char_start = 1'b1;
      res.char_index = cur.chars;
      mid.chars = sat_inc(cur.chars, COUNT_TOP);
      mid.leads = sat_inc(cur.leads, COUNT_TOP);
    end else if (data_byte != '0) begin
      res.char_start = 1'b1;
      res.char_index = cur.chars;
      mid.chars = sat_inc(cur.chars, COUNT_TOP);
    end
    mid.pos = sat_inc(cur.pos, MaxPos);
    if (last_byte && mid.pend != '0) begin
      mid.err = 1'b1;
    end
    err_out = mid.err;

    res.byte_offset     = cur.pos;
    res.encoding_error  = err_out;
    res.string_done     = last_byte;
    res.char_length     = err_out ? '0 : mid.chars;
    res.multibyte_count = err_out ? '0 : mid.leads;

    // string ends: everything starts over
    nxt = last_byte ? '0 : mid;
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import u8cbc_pkg::*;

  // byte offset saturates here; the block is built with the same value
  localparam int unsigned POS_TOP = MAX_STRING_BYTES_DEF;
  // cycles the result side holds ready low while bytes keep coming
  localparam int HOLD_CYCLES = 40;
  // bytes of random strings to send before the drain
  localparam int RANDOM_BYTES = 500;
  // slack after the last result
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT = 5000;
  localparam int DIRECTED_ROWS = 24;

  // running decode state of one string, as the block keeps it
  typedef struct packed {
    logic [PEND_W-1:0]  owed;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] chars;
    logic [COUNT_W-1:0] leads;
    logic               bad;
  } walk_t;

  // one directed row: the byte, its last flag, and a hand-written result
  // that is used only where typed is set
  typedef struct packed {
    logic [7:0] b;
    logic       lst;
    logic       typed;
    res_t       want;
  } row_t;

  logic clk;
  logic rst;

  u8cbc_in_if  in_ch ();
  u8cbc_out_if out_ch ();

  utf8_char_boundary_checker_core #(
    .MAX_STRING_BYTES(POS_TOP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  walk_t walk;
  res_t  expected_results[$];
  int    mismatch_cnt;
  int    result_cnt;
  int    random_bytes_sent;
  int    strings_sent;
  bit    calm;
  bit    hold_req;

  // directed bytes; columns after the flags are
  // start, index, offset, error, done, length, multibyte
  row_t stim_table [DIRECTED_ROWS] = '{
    // ascii, zero byte skipped, two-byte char, then a truncated three-byte lead
    {8'h41, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0, 1'b0, 8'd1, 8'd0},
    {8'h00, 1'b0, 1'b1, 1'b0, 8'd0, 8'd1, 1'b0, 1'b0, 8'd1, 8'd0},
    {8'hC3, 1'b0, 1'b1, 1'b1, 8'd1, 8'd2, 1'b0, 1'b0, 8'd2, 8'd1},
    {8'hA9, 1'b0, 1'b1, 1'b0, 8'd1, 8'd3, 1'b0, 1'b0, 8'd2, 8'd1},
    {8'hE2, 1'b1, 1'b1, 1'b1, 8'd2, 8'd4, 1'b1, 1'b1, 8'd0, 8'd0},
    // four-byte lead whose second continuation has bit 7 clear
    {8'hF0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0, 1'b0, 8'd1, 8'd1},
    {8'h9F, 1'b0, 1'b1, 1'b0, 8'd0, 8'd1, 1'b0, 1'b0, 8'd1, 8'd1},
    {8'h41, 1'b0, 1'b1, 1'b0, 8'd0, 8'd2, 1'b1, 1'b0, 8'd0, 8'd0},
    {8'h80, 1'b1, 1'b1, 1'b0, 8'd0, 8'd3, 1'b1, 1'b1, 8'd0, 8'd0},
    // lone continuation as a char, then the longest lead with all its bytes
    {8'h80, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0, 1'b0, 8'd1, 8'd1},
    {8'hFF, 1'b0, 1'b1, 1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 8'd2, 8'd2},
    {8'hBF, 1'b0, 1'b0, 35'd0},
    {8'h80, 1'b0, 1'b0, 35'd0},
    {8'hC0, 1'b0, 1'b0, 35'd0},
    {8'hFE, 1'b0, 1'b0, 35'd0},
    {8'h8F, 1'b0, 1'b0, 35'd0},
    {8'hBF, 1'b1, 1'b1, 1'b0, 8'd1, 8'd7, 1'b0, 1'b1, 8'd2, 8'd2},
    // one-byte strings: seven-byte lead cut short, top ascii, zero byte
    {8'hFE, 1'b1, 1'b0, 35'd0},
    {8'h7F, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0, 1'b1, 8'd1, 8'd0},
    {8'h00, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0, 8'd0},
    // five-byte lead, bad continuation, six-byte lead byte claimed, truncated
    {8'hF8, 1'b0, 1'b0, 35'd0},
    {8'h01, 1'b0, 1'b0, 35'd0},
    {8'hFC, 1'b1, 1'b0, 35'd0},
    {8'h55, 1'b1, 1'b0, 35'd0}
  };

  // advance the decode state by one byte and return the result it yields
  function automatic res_t predict_byte_result(input logic [7:0] b, input logic lst);
    res_t r;
    int   ones;
    r = '0;
    r.byte_offset = walk.pos;
    if (walk.owed != '0) begin
      // byte claimed by the open sequence, consumed even when malformed
      if (!b[7]) walk.bad = 1'b1;
      walk.owed = walk.owed - 1'b1;
      r.char_index = (walk.chars == '0) ? '0 : walk.chars - 1'b1;
      if (walk.chars == COUNT_TOP) r.char_index = COUNT_TOP;
    end else if (b[7]) begin
      // lead byte: leading ones give the sequence length, capped at 7
      ones = 1;
      for (int k = 6; k >= 1; k--) begin
        if (!b[k]) break;
        ones++;
      end
      walk.owed = PEND_W'(ones - 1);
      r.char_start = 1'b1;
      r.char_index = walk.chars;
      walk.chars = walk.chars + (walk.chars != COUNT_TOP);
      walk.leads = walk.leads + (walk.leads != COUNT_TOP);
    end else if (b != 8'h00) begin
      r.char_start = 1'b1;
      r.char_index = walk.chars;
      walk.chars = walk.chars + (walk.chars != COUNT_TOP);
    end
    walk.pos = (walk.pos >= COUNT_W'(POS_TOP)) ? COUNT_W'(POS_TOP) : walk.pos + 1'b1;
    // string ends with continuations still owed
    if (lst && walk.owed != '0) walk.bad = 1'b1;
    r.encoding_error  = walk.bad;
    r.string_done     = lst;
    r.char_length     = walk.bad ? '0 : walk.chars;
    r.multibyte_count = walk.bad ? '0 : walk.leads;
    if (lst) walk = '0;
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("start=%0d idx=%0d off=%0d err=%0d done=%0d len=%0d mb=%0d",
                     r.char_start, r.char_index, r.byte_offset, r.encoding_error,
                     r.string_done, r.char_length, r.multibyte_count);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // offer one byte from the next falling edge and return at the rising edge
  // that accepts it; valid stays high so back-to-back bytes need no gap
  task automatic send_byte(input logic [7:0] b, input logic lst,
                           input logic typed = 1'b0, input res_t want = '0);
    res_t predicted;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_byte_result(b, lst);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic stop_offering();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // one string of n_chars characters: mostly well-formed with random content,
  // some malformed sequences, some cut short, a few of pure noise
  task automatic send_random_string(input int n_chars);
    logic [7:0] bytes[$];
    logic [7:0] lead;
    int         kind;
    int         seq_len;
    int         bad_at;
    if ($urandom_range(0, 9) == 0) begin
      repeat (n_chars) bytes.push_back(8'($urandom));
    end else begin
      repeat (n_chars) begin
        kind = $urandom_range(0, 99);
        if (kind < 38) begin
          bytes.push_back(8'($urandom_range(1, 127)));
        end else if (kind < 43) begin
          bytes.push_back(8'h00);
        end else if (kind < 50) begin
          // stray continuation, counted as a char of its own
          bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end else begin
          bad_at = 0;
          if (kind < 64) seq_len = 2;
          else if (kind < 76) seq_len = 3;
          else if (kind < 86) seq_len = 4;
          else if (kind < 92) seq_len = $urandom_range(5, 7);
          else begin
            seq_len = $urandom_range(2, 4);
            bad_at = $urandom_range(1, seq_len - 1);
          end
          lead = ~(8'hFF >> seq_len) | (8'($urandom) & (8'hFF >> (seq_len + 1)));
          bytes.push_back(lead);
          for (int k = 1; k < seq_len; k++)
            bytes.push_back((k == bad_at) ? 8'($urandom_range(0, 127))
                                          : (8'h80 | 8'($urandom_range(0, 63))));
        end
      end
      // drop a byte or two so the string may end inside a sequence
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 2))
          if (bytes.size() > 1) void'(bytes.pop_back());
    end
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    random_bytes_sent += bytes.size();
    strings_sent++;
  endtask

  // free-running clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: ready low at random, 8 percent of the time, none during the calm stretch,
  // and one long hold-off when the stimulus asks for it
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // every accepted result is matched with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.char_start, out_ch.char_index, out_ch.byte_offset,
              out_ch.encoding_error, out_ch.string_done, out_ch.char_length,
              out_ch.multibyte_count};
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected: %s",
                                  result_cnt, show(got)));
      end else begin
        want = expected_results.pop_front();
        if (got !== want)
          report_mismatch($sformatf("result %0d got %s want %s",
                                    result_cnt, show(got), show(want)));
      end
      result_cnt++;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    walk = '0;
    mismatch_cnt = 0;
    result_cnt = 0;
    random_bytes_sent = 0;
    strings_sent = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows, typed results where they read off directly
    foreach (stim_table[i])
      send_byte(stim_table[i].b, stim_table[i].lst, stim_table[i].typed, stim_table[i].want);

    while (random_bytes_sent < RANDOM_BYTES) begin
      if (strings_sent == 8) begin
        // long hold on the result side while a string of 300 stray continuations
        // goes in: it fills the block and saturates offset, count and lead count
        hold_req = 1'b1;
        for (int i = 0; i < 300; i++)
          send_byte(8'h80 | 8'($urandom_range(0, 63)), i == 299);
        random_bytes_sent += 300;
        // hold input until every result is back
        stop_offering();
        while (expected_results.size() != 0) @(negedge clk);
      end
      calm = (strings_sent >= 20 && strings_sent < 35);
      send_random_string($urandom_range(1, 10));
    end
    calm = 1'b0;
    stop_offering();

    for (int i = 0; i < DRAIN_LIMIT && expected_results.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatch_cnt == 0) begin
      $display("utf8_char_boundary_checker_core test passed");
    end else begin
      $display("utf8_char_boundary_checker_core test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("utf8_char_boundary_checker_core test failed");
    $finish;
  end

endmodule
